// ===== rtl/address_pool_offer_commit_defines.svh =====
// Assertion macros used by the address pool engine
`ifndef ADDRESS_POOL_OFFER_COMMIT_DEFINES_SVH
`define ADDRESS_POOL_OFFER_COMMIT_DEFINES_SVH

// same-cycle implication, checked on clk, off during rst
`define APOC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk, off during rst
`define APOC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/apoc_pkg.sv =====
// Package: shared types and constants of the address pool
`timescale 1ns / 1ps
`default_nettype none

package apoc_pkg;

  localparam logic [31:0] GATEWAY_RST = 32'hC0A8_0101;
  localparam logic [31:0] MASK_RST    = 32'hFFFF_FF00;
  localparam logic [31:0] LEASE_RST   = 32'd3600;
  localparam logic [31:0] ZERO_ADDR   = 32'd0;

  localparam logic [1:0] REG_GATEWAY = 2'd0;
  localparam logic [1:0] REG_MASK    = 2'd1;
  localparam logic [1:0] REG_LEASE   = 2'd2;

  localparam logic KIND_OFFER = 1'b0;
  localparam logic KIND_ACK   = 1'b1;

  localparam logic [1:0] SLOT_CNT = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHK,
    ST_DISC,
    ST_REL,
    ST_DONE
  } apoc_state_t;

  typedef struct packed {
    logic taken;
    logic offered;
  } apoc_ent_t;

  typedef struct packed {
    logic [31:0] gateway;
    logic [31:0] mask;
  } apoc_cfg_t;

  typedef struct packed {
    logic idle;
    logic done;
  } apoc_stat_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] ack_addr;
    logic        hit;
    logic [31:0] addr_a;
    logic        vld_a;
    logic [31:0] addr_b;
    logic        vld_b;
    logic [31:0] addr_c;
    logic        vld_c;
  } apoc_res_t;

endpackage

`default_nettype wire

// ===== rtl/apoc_if.sv =====
// Request and reply channel interfaces of the address pool
`timescale 1ns / 1ps
`default_nettype none

interface apoc_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] client_addr;
  logic [31:0] xid;

  modport source(output valid, client_addr, xid, input ready);
  modport sink(input valid, client_addr, xid, output ready);
endinterface

interface apoc_rep_if;
  logic        valid;
  logic        ready;
  logic        reply_kind;
  logic [31:0] ack_addr;
  logic        request_hit;
  logic [31:0] offer_addr_a;
  logic        offer_valid_a;
  logic [31:0] offer_addr_b;
  logic        offer_valid_b;
  logic [31:0] offer_addr_c;
  logic        offer_valid_c;
  logic [31:0] xid_out;
  logic [31:0] lease_time;

  modport source(output valid, reply_kind, ack_addr, request_hit, offer_addr_a,
                 offer_valid_a, offer_addr_b, offer_valid_b, offer_addr_c,
                 offer_valid_c, xid_out, lease_time, input ready);
  modport sink(input valid, reply_kind, ack_addr, request_hit, offer_addr_a,
               offer_valid_a, offer_addr_b, offer_valid_b, offer_addr_c,
               offer_valid_c, xid_out, lease_time, output ready);
endinterface

`default_nettype wire

// ===== rtl/apoc_engine.sv =====
// Pool bitmap memory and the scan sequencer for discover and commit
`timescale 1ns / 1ps
`default_nettype none
`include "address_pool_offer_commit_defines.svh"

module apoc_engine
  import apoc_pkg::*;
#(
  parameter int POOL_SIZE = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] client_addr,
  input  apoc_cfg_t   cfg,
  input  logic        take,
  output apoc_stat_t  stat,
  output apoc_res_t   res
);

  localparam int IW = $clog2(POOL_SIZE);
  localparam int CW = $clog2(POOL_SIZE + 1);
  localparam logic [CW-1:0] LAST    = CW'(POOL_SIZE - 1);
  localparam logic [CW-1:0] END_CNT = CW'(POOL_SIZE);

  apoc_state_t state, state_next;
  logic [CW-1:0] scan_idx, scan_idx_next;
  logic          pend_vld;
  logic [IW-1:0] pend_idx;

  apoc_ent_t     mem [POOL_SIZE];
  apoc_ent_t     rd_ent;
  apoc_ent_t     wr_ent;
  logic          rd_en;
  logic          we;
  logic [IW-1:0] wr_addr;

  logic [31:0]   client;
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic [1:0]    found;
  logic          slot_take;
  logic [31:0]   slot_addr [3];
  logic [2:0]    slot_vld;

  logic [31:0]   base;
  logic [31:0]   lo;
  logic [31:0]   hmask;
  logic [32:0]   cidx;

  // entry k is usable when lo <= k and k + 1 < ~mask
  function automatic logic in_pool(input logic [31:0] k, input logic [31:0] lo_v,
                                   input logic [31:0] hm_v);
    return (k >= lo_v) && (({1'b0, k} + 33'd1) < {1'b0, hm_v});
  endfunction

  assign base  = cfg.gateway & cfg.mask;
  assign lo    = cfg.gateway & ~cfg.mask;
  assign hmask = ~cfg.mask;
  assign cidx  = {1'b0, client} - {1'b0, base} - 33'd1;

  assign slot_take = (state == ST_DISC) && pend_vld && (found != SLOT_CNT) &&
                     !rd_ent.offered && !rd_ent.taken &&
                     in_pool(32'(pend_idx), lo, hmask);

  always_comb begin
    state_next    = state;
    scan_idx_next = scan_idx;
    rd_en         = 1'b0;
    we            = 1'b0;
    wr_addr       = pend_idx;
    wr_ent        = '0;
    unique case (state)
      ST_CLEAR: begin
        we            = 1'b1;
        wr_addr       = scan_idx[IW-1:0];
        scan_idx_next = scan_idx + CW'(1);
        if (scan_idx == LAST) begin
          scan_idx_next = '0;
          state_next    = ST_IDLE;
        end
      end
      ST_IDLE: begin
        scan_idx_next = '0;
        if (start) begin
          state_next = (client_addr == ZERO_ADDR) ? ST_DISC : ST_CHK;
        end
      end
      ST_CHK: begin
        state_next = ST_REL;
      end
      ST_DISC: begin
        rd_en          = (scan_idx != END_CNT) && (found != SLOT_CNT);
        we             = slot_take;
        wr_ent.taken   = rd_ent.taken;
        wr_ent.offered = 1'b1;
        scan_idx_next  = scan_idx + CW'(rd_en);
        if ((found == SLOT_CNT) || ((scan_idx == END_CNT) && !pend_vld)) begin
          state_next = ST_DONE;
        end
      end
      ST_REL: begin
        rd_en         = (scan_idx != END_CNT);
        we            = pend_vld;
        scan_idx_next = scan_idx + CW'(rd_en);
        if (hit && (pend_idx == hit_idx)) begin
          wr_ent = '{taken: 1'b1, offered: 1'b1};
        end else begin
          wr_ent.taken   = rd_ent.taken;
          wr_ent.offered = rd_ent.offered & rd_ent.taken;
        end
        if ((scan_idx == END_CNT) && !pend_vld) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      scan_idx <= '0;
      pend_vld <= 1'b0;
      found    <= '0;
      slot_vld <= '0;
      hit      <= 1'b0;
    end else begin
      state    <= state_next;
      scan_idx <= scan_idx_next;
      pend_vld <= rd_en;
      if (state == ST_IDLE && start) begin
        found    <= '0;
        slot_vld <= '0;
        hit      <= 1'b0;
      end else if (state == ST_CHK) begin
        hit <= !cidx[32] && (cidx[31:0] < 32'(POOL_SIZE)) && in_pool(cidx[31:0], lo, hmask);
      end else if (slot_take) begin
        found           <= found + 2'd1;
        slot_vld[found] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      pend_idx <= scan_idx[IW-1:0];
    end
    if (state == ST_IDLE && start) begin
      client       <= client_addr;
      slot_addr[0] <= '0;
      slot_addr[1] <= '0;
      slot_addr[2] <= '0;
    end
    if (state == ST_CHK) begin
      hit_idx <= cidx[IW-1:0];
    end
    if (slot_take) begin
      slot_addr[found] <= base + 32'(pend_idx) + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_ent;
    end
    if (rd_en) begin
      rd_ent <= mem[scan_idx[IW-1:0]];
    end
  end

  assign stat.idle = (state == ST_IDLE);
  assign stat.done = (state == ST_DONE);

  assign res.kind     = (client != ZERO_ADDR) ? KIND_ACK : KIND_OFFER;
  assign res.ack_addr = client;
  assign res.hit      = hit;
  assign res.addr_a   = slot_addr[0];
  assign res.vld_a    = slot_vld[0];
  assign res.addr_b   = slot_addr[1];
  assign res.vld_b    = slot_vld[1];
  assign res.addr_c   = slot_addr[2];
  assign res.vld_c    = slot_vld[2];

  `APOC_ASSERT_IMP(a_slot_b_after_a, slot_vld[1], slot_vld[0], "offer slot b filled before a")
  `APOC_ASSERT_IMP(a_slot_c_after_b, slot_vld[2], slot_vld[1], "offer slot c filled before b")
  `APOC_ASSERT_IMP(a_wr_has_data, we && (state != ST_CLEAR), pend_vld, "write without read data")
  `APOC_ASSERT_NXT(a_start_busy, start && (state == ST_IDLE), state != ST_IDLE, "start ignored")

endmodule

`default_nettype wire

// ===== rtl/address_pool_offer_commit.sv =====
// Top level: address pool with offer and commit, APB registers, reply register
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    client_addr, xid
//   rep      out  valid/ready    reply_kind .. lease_time
//   apb      in   psel/penable   gateway_addr, netmask, lease_seconds
//
// From acceptance to the load of the reply register a discover sweeps the
// bitmap memory one entry per cycle until three offer slots fill or it ends;
// a commit sweeps all of it. The engine returns to idle before a new request
// is taken. After rst a clearing pass of every entry runs with req.ready low.
// The reply register holds a finished reply while rep.ready is low; the next
// request is taken meanwhile, and its reply waits until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module address_pool_offer_commit
  import apoc_pkg::*;
#(
  parameter int POOL_SIZE = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  apoc_req_if.sink    req,
  apoc_rep_if.source  rep
);

  apoc_cfg_t   cfg;
  logic [31:0] lease;
  logic        cfg_we;
  logic [1:0]  reg_idx;

  logic        start;
  logic        take;
  apoc_stat_t  stat;
  apoc_res_t   res;
  apoc_res_t   res_q;
  logic [31:0] xid_q;
  logic [31:0] xid_out;
  logic [31:0] lease_out;
  logic        out_vld;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gateway <= GATEWAY_RST;
      cfg.mask    <= MASK_RST;
      lease       <= LEASE_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_GATEWAY: cfg.gateway <= pwdata;
        REG_MASK:    cfg.mask    <= pwdata;
        REG_LEASE:   lease       <= pwdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GATEWAY: prdata = cfg.gateway;
      REG_MASK:    prdata = cfg.mask;
      REG_LEASE:   prdata = lease;
      default:     prdata = '0;
    endcase
  end

  assign req.ready = stat.idle;
  assign start     = req.valid && stat.idle;
  assign take      = stat.done && (!out_vld || rep.ready);

  apoc_engine #(
    .POOL_SIZE(POOL_SIZE)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .client_addr(req.client_addr),
    .cfg        (cfg),
    .take       (take),
    .stat       (stat),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (start) begin
      xid_q <= req.xid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (take) begin
      out_vld <= 1'b1;
    end else if (rep.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q     <= res;
      xid_out   <= xid_q;
      lease_out <= lease;
    end
  end

  assign rep.valid         = out_vld;
  assign rep.reply_kind    = res_q.kind;
  assign rep.ack_addr      = res_q.ack_addr;
  assign rep.request_hit   = res_q.hit;
  assign rep.offer_addr_a  = res_q.addr_a;
  assign rep.offer_valid_a = res_q.vld_a;
  assign rep.offer_addr_b  = res_q.addr_b;
  assign rep.offer_valid_b = res_q.vld_b;
  assign rep.offer_addr_c  = res_q.addr_c;
  assign rep.offer_valid_c = res_q.vld_c;
  assign rep.xid_out       = xid_out;
  assign rep.lease_time    = lease_out;

endmodule

`default_nettype wire
